/* hdl/ppm_frame_decoder_core_assert.svh */
// assertion macros for the ppm frame decoder checker
// clocked on aclk, disabled while aresetn is low unless the name says otherwise
`ifndef PPM_FRAME_DECODER_CORE_ASSERT_SVH
`define PPM_FRAME_DECODER_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define PPMFD_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ppmfd check failed");

// next-cycle implication, held off during reset
`define PPMFD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ppmfd check failed");

// next-cycle implication that is also checked during reset
`define PPMFD_ASSERT_RESET(name, ante, cons) \
    name: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("ppmfd reset check failed");

`endif

/* hdl/ppmfd_pkg.sv */
// shared constants, command and divider types for the ppm frame decoder
// no dependencies
package ppmfd_pkg;

    localparam int CHANNELS = 4;
    localparam int SLOTS    = 8;

    // field widths fixed by the interface
    localparam int CHAN_W  = 2;
    localparam int TIME_W  = 16;
    localparam int SLOT_W  = 4;
    localparam int WIDTH_W = 16;
    localparam int CLK_W   = 8;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CUR_W      = $clog2(SLOTS + 1);
    localparam int MEM_DEPTH  = CHANNELS * SLOTS;
    localparam int MEM_AW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // ticks * 64 is a shift by six
    localparam int PRESCALE_SHIFT = 6;
    localparam int DIV_CNT_W      = $clog2(WIDTH_W);

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [CLK_W-1:0]  CLOCK_RESET   = 8'd40;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register select taken from paddr[2]
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_CLOCK   = 1'b1;

    typedef struct packed {
        logic [CH_IDX_W-1:0]   chan;
        logic [SLOT_IDX_W-1:0] slot;
        logic [TIME_W-1:0]     ticks;
        logic                  wr;
        logic                  emit;
    } ppmfd_cmd_t;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] ticks;
        logic [CLK_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [WIDTH_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [MEM_AW-1:0] store_addr(
        input logic [CH_IDX_W-1:0]   chan,
        input logic [SLOT_IDX_W-1:0] slot
    );
        return MEM_AW'(chan) * MEM_AW'(SLOTS) + MEM_AW'(slot);
    endfunction

endpackage

/* hdl/ppmfd_front.sv */
// front end: takes edge timestamps, tracks per-channel sync and slot cursor,
// and issues store / emit commands to the queue; uses ppmfd_pkg
module ppmfd_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ppmfd_pkg::CHAN_W-1:0]    s_chan_id,
    input  logic [ppmfd_pkg::TIME_W-1:0]    s_edge_time,
    input  logic [ppmfd_pkg::TIME_W-1:0]    sync_timeout,
    input  logic                            q_full,
    output logic                            cmd_push,
    output ppmfd_pkg::ppmfd_cmd_t           cmd
);
    import ppmfd_pkg::*;

    logic [TIME_W-1:0] prev_reg   [CHANNELS];
    logic [CUR_W-1:0]  cursor_reg [CHANNELS];
    logic [CHANNELS-1:0] synced_reg;

    logic                accept;
    logic                ch_ok;
    logic [CH_IDX_W-1:0] ch;
    logic [TIME_W-1:0]   delta;
    logic                is_sync;
    logic [CUR_W-1:0]    cur;
    logic                room;
    logic [CUR_W-1:0]    cur_next;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign ch_ok    = int'(s_chan_id) < CHANNELS;
    assign ch       = CH_IDX_W'(s_chan_id);

    always_comb begin
        delta    = s_edge_time - prev_reg[ch];
        is_sync  = delta > sync_timeout;
        cur      = cursor_reg[ch];
        room     = cur < CUR_W'(SLOTS);
        cur_next = room ? cur + CUR_W'(1) : cur;

        cmd.chan  = ch;
        cmd.slot  = SLOT_IDX_W'(cur);
        cmd.ticks = delta;
        cmd.wr    = room;
        cmd.emit  = cur_next == CUR_W'(SLOTS);

        // a short interval on a synced channel always needs the back end
        cmd_push = accept && ch_ok && !is_sync && synced_reg[ch];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            synced_reg <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                prev_reg[i]   <= '0;
                cursor_reg[i] <= '0;
            end
        end else if (accept && ch_ok) begin
            prev_reg[ch] <= s_edge_time;
            if (is_sync) begin
                synced_reg[ch] <= 1'b1;
                cursor_reg[ch] <= '0;
            end else if (synced_reg[ch]) begin
                cursor_reg[ch] <= cur_next;
            end
        end
    end

endmodule

/* hdl/ppmfd_queue.sv */
// short command queue between front and back end
// uses ppmfd_pkg for the command type and depth
module ppmfd_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ppmfd_pkg::ppmfd_cmd_t cmd_in,
    output logic                  full,
    input  logic                  pop,
    output ppmfd_pkg::ppmfd_cmd_t head,
    output logic                  empty
);
    import ppmfd_pkg::*;

    ppmfd_cmd_t        entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full    = count_reg == QCNT_W'(QDEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* hdl/ppmfd_div.sv */
// bit-serial divider: quotient = (ticks * 64) / divisor, saturated to 16 bits
// one quotient bit per cycle; uses ppmfd_pkg request / response types
module ppmfd_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  ppmfd_pkg::div_req_t req,
    output ppmfd_pkg::div_rsp_t rsp
);
    import ppmfd_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CLK_W-1:0]     rem_reg;
    logic [CLK_W-1:0]     divisor_reg;
    logic [WIDTH_W-1:0]   sh_reg;
    logic [WIDTH_W-1:0]   quo_reg;

    logic [TIME_W-1:0] hi_part;
    logic              sat;
    logic [CLK_W:0]    trial;
    logic              ge;

    // bits of ticks*64 above the quotient range; result saturates when they reach divisor
    assign hi_part = req.ticks >> (TIME_W - PRESCALE_SHIFT);
    assign sat     = hi_part >= TIME_W'(req.divisor);
    assign trial   = {rem_reg, sh_reg[WIDTH_W-1]};
    assign ge      = trial >= {1'b0, divisor_reg};

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (req.start) begin
            divisor_reg <= req.divisor;
            rem_reg     <= CLK_W'(hi_part);
            sh_reg      <= req.ticks << PRESCALE_SHIFT;
            cnt_reg     <= DIV_CNT_W'(WIDTH_W - 1);
            quo_reg     <= sat ? '1 : '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? CLK_W'(trial - {1'b0, divisor_reg}) : CLK_W'(trial);
            sh_reg  <= sh_reg << 1;
            quo_reg <= {quo_reg[WIDTH_W-2:0], ge};
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= !sat;
                done_reg <= sat;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

/* hdl/ppmfd_back.sv */
// back end: pulse store memory, frame walk through the divider, output register
// instantiates ppmfd_div; uses ppmfd_pkg
module ppmfd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ppmfd_pkg::ppmfd_cmd_t         head,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  logic [ppmfd_pkg::CLK_W-1:0]   clock_mhz,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ppmfd_pkg::CHAN_W-1:0]  m_out_chan,
    output logic [ppmfd_pkg::SLOT_W-1:0]  m_slot_index,
    output logic [ppmfd_pkg::WIDTH_W-1:0] m_width_us,
    output logic                          m_last_slot
);
    import ppmfd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RD    = 5'b00010,
        S_START = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;

    logic [TIME_W-1:0]     mem [MEM_DEPTH];
    logic [TIME_W-1:0]     rdata_reg;
    logic [CH_IDX_W-1:0]   chan_reg;
    logic [SLOT_IDX_W-1:0] k_reg;
    logic                  valid_reg;
    logic [CHAN_W-1:0]     out_chan_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [WIDTH_W-1:0]    width_reg;
    logic                  last_reg;

    logic              k_last;
    logic              out_hs;
    logic              mem_we;
    logic [MEM_AW-1:0] wr_addr;
    logic [MEM_AW-1:0] rd_addr;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    ppmfd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign q_pop   = (state_reg == S_IDLE) && !q_empty;
    assign mem_we  = q_pop && head.wr;
    assign wr_addr = store_addr(head.chan, head.slot);
    assign rd_addr = store_addr(chan_reg, k_reg);
    assign k_last  = k_reg == SLOT_IDX_W'(SLOTS - 1);
    assign out_hs  = valid_reg && m_tready;

    assign div_req.start   = state_reg == S_START;
    assign div_req.ticks   = rdata_reg;
    // a zero clock setting divides by one
    assign div_req.divisor = (clock_mhz == '0) ? CLK_W'(1) : clock_mhz;

    assign m_tvalid     = valid_reg;
    assign m_out_chan   = out_chan_reg;
    assign m_slot_index = slot_reg;
    assign m_width_us   = width_reg;
    assign m_last_slot  = last_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (q_pop && head.emit) begin
                    state_next = S_RD;
                end
            end
            S_RD:    state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV: begin
                if (div_rsp.done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_hs) begin
                    state_next = k_last ? S_IDLE : S_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= head.ticks;
        end
        if (state_reg == S_RD) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && head.emit) begin
            chan_reg <= head.chan;
        end
        if (state_reg == S_DIV && div_rsp.done) begin
            out_chan_reg <= CHAN_W'(chan_reg);
            slot_reg     <= SLOT_W'(k_reg);
            width_reg    <= div_rsp.quotient;
            last_reg     <= k_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_IDLE) begin
                k_reg <= '0;
            end else if (state_reg == S_OUT && out_hs && !k_last) begin
                k_reg <= k_reg + SLOT_IDX_W'(1);
            end
            if (state_reg == S_DIV && div_rsp.done) begin
                valid_reg <= 1'b1;
            end else if (out_hs) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hdl/ppm_frame_decoder_core.sv */
// top level of the ppm frame decoder: stream ports, apb registers, front/queue/back
// instantiates ppmfd_front, ppmfd_queue, ppmfd_back; uses ppmfd_pkg
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------------
//  s_        | in        | s_tvalid / s_tready     | chan_id, edge_time
//  m_        | out       | m_tvalid / m_tready     | out_chan, slot_index, width_us, tlast
//  apb       | in        | psel, penable, pready=1 | sync_timeout_ticks @0, clock_mhz @4
//
// an edge request is taken whenever the two-entry command queue has room
// each emitted frame walks SLOTS store entries; each slot reads the store, runs the
// bit-serial divider (16 steps) and waits in the output register for m_tready
// a saturated slot skips the divider steps
// aresetn clears cursors, sync flags, previous times, queue and output valid, reloads config; no clearing pass
// the output register holds its result under m_tready low while edges keep queuing until the queue is full
module ppm_frame_decoder_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [1:0] chan_id, [17:2] edge_time, [23:18] zero
    input  logic [ppmfd_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] out_chan, [5:2] slot_index, [21:6] width_us, [23:22] zero
    output logic [ppmfd_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppmfd_pkg::PADDR_W-1:0]      paddr,
    input  logic [ppmfd_pkg::PDATA_W-1:0]      pwdata,
    output logic [ppmfd_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);
    import ppmfd_pkg::*;

    logic [TIME_W-1:0] timeout_reg;
    logic [CLK_W-1:0]  clock_reg;

    logic              cfg_wr;
    logic              reg_sel;
    logic              cmd_push;
    ppmfd_cmd_t        cmd;
    ppmfd_cmd_t        head;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic [CHAN_W-1:0]  out_chan;
    logic [SLOT_W-1:0]  slot_index;
    logic [WIDTH_W-1:0] width_us;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_TIMEOUT: prdata = PDATA_W'(timeout_reg);
            REG_CLOCK:   prdata = PDATA_W'(clock_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            clock_reg   <= CLOCK_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_TIMEOUT: timeout_reg <= pwdata[TIME_W-1:0];
                REG_CLOCK:   clock_reg   <= pwdata[CLK_W-1:0];
                default:     timeout_reg <= timeout_reg;
            endcase
        end
    end

    ppmfd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_chan_id    (s_tdata[CHAN_W-1:0]),
        .s_edge_time  (s_tdata[CHAN_W +: TIME_W]),
        .sync_timeout (timeout_reg),
        .q_full       (q_full),
        .cmd_push     (cmd_push),
        .cmd          (cmd)
    );

    ppmfd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (cmd_push),
        .cmd_in  (cmd),
        .full    (q_full),
        .pop     (q_pop),
        .head    (head),
        .empty   (q_empty)
    );

    ppmfd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .clock_mhz    (clock_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_out_chan   (out_chan),
        .m_slot_index (slot_index),
        .m_width_us   (width_us),
        .m_last_slot  (m_tlast)
    );

    assign m_tdata = {(M_TDATA_W - CHAN_W - SLOT_W - WIDTH_W)'(0), width_us, slot_index,
                      out_chan};

endmodule

/* hdl/ppmfd_checker.sv */
// port-level checker for the ppm frame decoder, bound to the top level
// uses ppmfd_pkg and the assertion macros header
`include "ppm_frame_decoder_core_assert.svh"

module ppmfd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ppmfd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tlast
);
    import ppmfd_pkg::*;

    // a stalled result keeps its payload
    `PPMFD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // the frame marker only comes with the final slot
    `PPMFD_ASSERT_NOW(a_last_slot_index, m_tvalid && m_tlast, m_tdata[5:2] == SLOT_W'(SLOTS - 1))

    // the end of a frame always leaves a gap before the next result
    `PPMFD_ASSERT_NEXT(a_gap_after_frame, m_tvalid && m_tready && m_tlast, !m_tvalid)

    // reset empties the output and the command queue
    `PPMFD_ASSERT_RESET(a_reset_state, !aresetn, !m_tvalid && s_tready)

endmodule

bind ppm_frame_decoder_core ppmfd_checker u_checker (.*);

/* dv/ppm_frame_decoder_core_tb.sv */
// self-checking testbench for ppm_frame_decoder_core: edge timestamps in, decoded frames out
// needs ppmfd_pkg and the decoder rtl; a local model predicts random and untyped slots, typed rows give the rest
module ppm_frame_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppmfd_pkg::*;

    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 70;
    localparam int REPORT_LIMIT   = 10;
    localparam int NOT_TYPED      = -1;

    typedef struct packed {
        logic [CHAN_W-1:0]  chan;
        logic [SLOT_W-1:0]  slot;
        logic [WIDTH_W-1:0] width;
        logic               last;
    } slot_result_t;

    typedef enum logic {ROW_EDGE, ROW_CFG} row_kind_t;

    // edge rows: value is the interval to the channel's previous edge
    // config rows: sel picks the register, value is written to it
    typedef struct {
        row_kind_t          kind;
        logic [CHAN_W-1:0]  chan;
        logic               sel;
        int unsigned        value;
        int                 reps;
        int                 typed_n;
        logic [WIDTH_W-1:0] typed_w;
    } plan_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tready = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [M_TDATA_W-1:0] m_tdata;
    wire                  m_tlast;
    wire  [PDATA_W-1:0]   prdata;
    wire                  pready;

    ppm_frame_decoder_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // decoder model state
    logic [TIME_W-1:0] last_edge [CHANNELS];
    int                fill_cnt [CHANNELS];
    bit                locked [CHANNELS];
    logic [TIME_W-1:0] held_ticks [CHANNELS*SLOTS];
    logic [TIME_W-1:0] timeout_reg = TIMEOUT_RESET;
    logic [CLK_W-1:0]  clock_reg   = CLOCK_RESET;

    slot_result_t      frame_buf [SLOTS];
    slot_result_t      frame_q [$];
    logic [TIME_W-1:0] tx_prev [CHANNELS];
    int                sent        = 0;
    int                mismatches  = 0;
    int                idle_cycles = 0;
    int                rx_hold     = 0;
    bit                calm        = 1'b0;

    function automatic logic [WIDTH_W-1:0] ticks_to_us(input logic [TIME_W-1:0] ticks);
        int unsigned div;
        int unsigned q;
        div = (clock_reg == 0) ? 1 : clock_reg;
        q = (32'(ticks) * 32'd64) / div;
        return (q > 32'hFFFF) ? 16'hFFFF : q[WIDTH_W-1:0];
    endfunction

    // updates the model for one edge, returns how many slots land in frame_buf
    function automatic int decode_edge(input logic [CHAN_W-1:0] ch,
                                       input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] interval;
        int                base;
        int                k;
        if (ch >= CHANNELS)
            return 0;
        interval = now - last_edge[ch];
        last_edge[ch] = now;
        if (interval > timeout_reg) begin
            locked[ch] = 1'b1;
            fill_cnt[ch] = 0;
            return 0;
        end
        if (!locked[ch])
            return 0;
        base = ch * SLOTS;
        if (fill_cnt[ch] < SLOTS) begin
            held_ticks[base + fill_cnt[ch]] = interval;
            fill_cnt[ch]++;
        end
        if (fill_cnt[ch] != SLOTS)
            return 0;
        for (k = 0; k < SLOTS; k++)
            frame_buf[k] = '{ch, k[SLOT_W-1:0], ticks_to_us(held_ticks[base + k]),
                             k == SLOTS - 1};
        return SLOTS;
    endfunction

    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch: %s", msg);
    endfunction

    function automatic int tx_gap_len();
        if (calm)
            return 0;
        if ($urandom_range(0, 11) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(0, 2);
    endfunction

    // short interval, biased toward small tick counts so the divider sees both ranges
    function automatic logic [TIME_W-1:0] short_gap();
        int unsigned cap;
        cap = (timeout_reg > 1200) ? 1200 : timeout_reg;
        return 16'($urandom_range(0, $urandom_range(0, 1) ? cap : timeout_reg));
    endfunction

    task automatic send_edge(input logic [CHAN_W-1:0] ch, input logic [TIME_W-1:0] t,
                             input bit keep);
        int n;
        int k;
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - CHAN_W - TIME_W){1'b0}}, t, ch};
        do @(posedge aclk); while (!s_tready);
        tx_prev[ch] = t;
        sent++;
        n = decode_edge(ch, t);
        if (keep)
            for (k = 0; k < n; k++)
                frame_q.push_back(frame_buf[k]);
        gap = tx_gap_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // hold the sender until every predicted slot is out, then let the block settle
    task automatic drain(input int settle);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (frame_q.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input logic sel, input logic [PDATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_CLOCK)
            clock_reg = value[CLK_W-1:0];
        else
            timeout_reg = value[TIME_W-1:0];
    endtask

    // result side backpressure
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                rx_hold = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 3);
        end
    end

    always @(posedge aclk) begin
        slot_result_t got;
        slot_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[CHAN_W-1:0], m_tdata[CHAN_W +: SLOT_W],
                    m_tdata[CHAN_W + SLOT_W +: WIDTH_W], m_tlast};
            if (frame_q.size() == 0) begin
                flag_error($sformatf("no slot pending, got ch %0d slot %0d width %0d last %0d",
                                     got.chan, got.slot, got.width, got.last));
            end else begin
                want = frame_q.pop_front();
                if (got.chan !== want.chan || got.slot !== want.slot ||
                    got.width !== want.width || got.last !== want.last)
                    flag_error($sformatf(
                        "expected ch %0d slot %0d width %0d last %0d, got ch %0d slot %0d width %0d last %0d",
                        want.chan, want.slot, want.width, want.last,
                        got.chan, got.slot, got.width, got.last));
            end
        end
    end

    // watchdog: too long without any request moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        plan_row_t         plan [$];
        plan_row_t         row;
        int                k;
        int                rand_start;
        int                phase_end;
        int                n;
        int                pick;
        logic [CHAN_W-1:0] ch;
        logic [PDATA_W-1:0] val;

        for (k = 0; k < CHANNELS; k++) begin
            last_edge[k] = '0;
            fill_cnt[k]  = 0;
            locked[k]    = 1'b0;
            tx_prev[k]   = '0;
        end
        for (k = 0; k < CHANNELS * SLOTS; k++)
            held_ticks[k] = '0;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // reset values: timeout 3000, clock 40
        // short interval before the channel has synced
        plan.push_back('{ROW_EDGE, 2'd0, 1'b0, 100,   1, 0, 16'd0});
        // one tick above the timeout is sync
        plan.push_back('{ROW_EDGE, 2'd0, 1'b0, 3001,  1, 0, 16'd0});
        // zero intervals fill the frame
        plan.push_back('{ROW_EDGE, 2'd0, 1'b0, 0,     8, 8, 16'd0});
        // interval equal to the timeout is short, full frame is sent again
        plan.push_back('{ROW_EDGE, 2'd0, 1'b0, 3000,  1, 8, 16'd0});
        plan.push_back('{ROW_EDGE, 2'd1, 1'b0, 65000, 1, 0, 16'd0});
        // timer wraps during this frame
        plan.push_back('{ROW_EDGE, 2'd1, 1'b0, 2000,  8, 8, 16'd3200});
        plan.push_back('{ROW_CFG,  2'd0, REG_CLOCK, 1, 0, 0, 16'd0});
        // conversion saturates
        plan.push_back('{ROW_EDGE, 2'd1, 1'b0, 2000,  1, 8, 16'hFFFF});
        // zero divisor, on a channel whose stored intervals are all zero
        plan.push_back('{ROW_CFG,  2'd0, REG_CLOCK, 0, 0, 0, 16'd0});
        plan.push_back('{ROW_EDGE, 2'd0, 1'b0, 100,   1, 8, 16'd0});
        plan.push_back('{ROW_CFG,  2'd0, REG_CLOCK, 255, 0, 0, 16'd0});
        plan.push_back('{ROW_CFG,  2'd0, REG_TIMEOUT, 0, 0, 0, 16'd0});
        plan.push_back('{ROW_EDGE, 2'd2, 1'b0, 1,     1, 0, 16'd0});
        plan.push_back('{ROW_EDGE, 2'd2, 1'b0, 0,     1, NOT_TYPED, 16'd0});
        // at the top timeout nothing counts as sync
        plan.push_back('{ROW_CFG,  2'd0, REG_TIMEOUT, 65535, 0, 0, 16'd0});
        plan.push_back('{ROW_EDGE, 2'd3, 1'b0, 65535, 1, 0, 16'd0});
        plan.push_back('{ROW_EDGE, 2'd1, 1'b0, 65535, 1, NOT_TYPED, 16'd0});

        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_CFG) begin
                drain(SETTLE_CYCLES);
                write_reg(row.sel, row.value);
            end else begin
                // typed slots only come from the last edge of the row, queue them first
                for (k = 0; k < row.typed_n; k++)
                    frame_q.push_back('{row.chan, k[SLOT_W-1:0], row.typed_w,
                                        k == SLOTS - 1});
                repeat (row.reps)
                    send_edge(row.chan, tx_prev[row.chan] + row.value[TIME_W-1:0],
                              row.typed_n == NOT_TYPED);
            end
        end

        rand_start = sent;
        while (sent - rand_start < RANDOM_ITEMS) begin
            drain(SETTLE_CYCLES);
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 4))
                0:       val = TIMEOUT_RESET;
                1:       val = 0;
                2:       val = 32'hFFFF;
                3:       val = $urandom_range(50, 5000);
                default: val = $urandom_range(0, 65535);
            endcase
            write_reg(REG_TIMEOUT, val);
            case ($urandom_range(0, 4))
                0:       val = CLOCK_RESET;
                1:       val = 1;
                2:       val = 0;
                3:       val = 255;
                default: val = $urandom_range(1, 255);
            endcase
            write_reg(REG_CLOCK, val);

            phase_end = sent + $urandom_range(15, 35);
            while (sent < phase_end) begin
                ch   = $urandom_range(0, CHANNELS - 1);
                pick = $urandom_range(0, 9);
                if (pick < 8) begin
                    // sync (below the top timeout) then a frame's worth of pulses plus up to two, sometimes fewer
                    n = (pick == 0) ? $urandom_range(1, SLOTS - 1)
                                    : SLOTS + $urandom_range(0, 2);
                    if (timeout_reg != 16'hFFFF)
                        send_edge(ch, tx_prev[ch] +
                                  16'($urandom_range(timeout_reg + 1, 65535)), 1'b1);
                    repeat (n)
                        send_edge(ch, tx_prev[ch] + short_gap(), 1'b1);
                end else begin
                    send_edge(ch, 16'($urandom), 1'b1);
                end
                if ($urandom_range(0, 19) == 0)
                    drain(0);
            end
        end

        drain(SETTLE_CYCLES);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ppmfd_pkg.sv
hdl/ppmfd_front.sv
hdl/ppmfd_queue.sv
hdl/ppmfd_div.sv
hdl/ppmfd_back.sv
hdl/ppm_frame_decoder_core.sv
hdl/ppmfd_checker.sv
dv/ppm_frame_decoder_core_tb.sv
